// ----- sv/dnt_pkg.sv -----
// Shared types, constants and helper functions of the directory name table.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package dnt_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NAME_BYTES = 9;
  localparam int NAME_W   = 8 * NAME_BYTES;
  localparam int HEAD_W   = 64;
  localparam int TAIL_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int SECTOR_W = 10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and restart the scan
    logic scan;    // step the slot scan by one slot
    logic commit;  // update the table and load the result register
  } dnt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } dnt_stat_t;

  // Forces every byte after the first zero byte to zero. Two names match
  // exactly when their normalized forms are equal.
  function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] name);
    logic [NAME_W-1:0] res;
    logic              ended;
    logic [7:0]        b;
    res   = '0;
    ended = 1'b0;
    for (int p = 0; p < NAME_BYTES; p++) begin
      b = ended ? 8'd0 : name[8*p +: 8];
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      res[8*p +: 8] = b;
    end
    return res;
  endfunction

  // Low bits of a slot number as carried in the result.
  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [7:0] wide;
    wide = 8'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ----- sv/dnt_if.sv -----
// Valid/ready channel interfaces for requests and results of the name table.
// Depends on dnt_pkg.
interface dnt_in_if import dnt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HEAD_W-1:0]   name_head;
  logic [TAIL_W-1:0]   name_tail;
  logic [SECTOR_W-1:0] sector_in;
  logic                dir_flag_in;

  modport source (output valid, func, name_head, name_tail, sector_in, dir_flag_in,
                  input ready);
  modport sink   (input valid, func, name_head, name_tail, sector_in, dir_flag_in,
                  output ready);
endinterface

interface dnt_out_if import dnt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [SECTOR_W-1:0] sector_out;
  logic                is_dir;

  modport source (output valid, status, slot_index, sector_out, is_dir, input ready);
  modport sink   (input valid, status, slot_index, sector_out, is_dir, output ready);
endinterface

// ----- sv/dnt_ctrl.sv -----
// Controller of the name table: sequences accept, slot scan and commit.
// Depends on dnt_pkg.
module dnt_ctrl import dnt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dnt_cmd_t  cmd,
  input  dnt_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold the finished result until the output register is free.
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/dnt_dpath.sv -----
// Datapath of the name table: slot memory, valid bits, scan pipeline and result register.
// Depends on dnt_pkg.
module dnt_dpath import dnt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dnt_cmd_t            cmd,
  output dnt_stat_t           stat,
  input  logic [FUNC_W-1:0]   func,
  input  logic [HEAD_W-1:0]   name_head,
  input  logic [TAIL_W-1:0]   name_tail,
  input  logic [SECTOR_W-1:0] sector_in,
  input  logic                dir_flag_in,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [SECTOR_W-1:0] sector_out,
  output logic                is_dir
);

  // Slot storage; only valid slots are ever compared, so no clearing is needed.
  logic [NAME_W-1:0]   name_mem   [ENTRIES];
  logic [SECTOR_W-1:0] sector_mem [ENTRIES];
  logic                dir_mem    [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;

  // Request registers.
  logic [FUNC_W-1:0]   func_r;
  logic [NAME_W-1:0]   name_r;
  logic [SECTOR_W-1:0] sector_r;
  logic                dir_r;

  // Scan: issue stage and compare stage.
  logic [IDX_W-1:0]    idx_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                cmp_vld_r;
  logic [NAME_W-1:0]   rd_name_r;
  logic [SECTOR_W-1:0] rd_sector_r;
  logic                rd_dir_r;
  logic                match;

  // Scan findings.
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [SECTOR_W-1:0] hit_sector_r;
  logic                hit_dir_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;

  // Result register.
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SECTOR_W-1:0] sector_out_r, sector_out_nxt;
  logic                is_dir_r, is_dir_nxt;
  logic                wr_en, clr_en;

  assign match          = cmp_vld_r && valid_r[cmp_idx_r] && (rd_name_r == name_r);
  assign stat.scan_done = cmp_vld_r && (match || (cmp_idx_r == LAST_IDX));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= func;
      name_r   <= normalize_name({name_tail, name_head});
      sector_r <= sector_in;
      dir_r    <= dir_flag_in;
      idx_r    <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan) begin
      if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + 1'b1;
      end
      if (match) begin
        hit_r        <= 1'b1;
        hit_idx_r    <= cmp_idx_r;
        hit_sector_r <= rd_sector_r;
        hit_dir_r    <= rd_dir_r;
      end
      if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
    end
    rd_name_r   <= name_mem[idx_r];
    rd_sector_r <= sector_mem[idx_r];
    rd_dir_r    <= dir_mem[idx_r];
    cmp_idx_r   <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
    end
  end

  always_comb begin
    status_nxt     = ST_NOT_FOUND;
    slot_nxt       = '0;
    sector_out_nxt = '0;
    is_dir_nxt     = 1'b0;
    wr_en          = 1'b0;
    clr_en         = 1'b0;
    case (func_r)
      FUNC_LOOKUP: begin
        if (hit_r) begin
          status_nxt     = ST_DONE;
          slot_nxt       = slot_field(hit_idx_r);
          sector_out_nxt = hit_sector_r;
          is_dir_nxt     = hit_dir_r;
        end
      end
      FUNC_ADD: begin
        if (hit_r) begin
          status_nxt = ST_DUPLICATE;
        end else if (free_found_r) begin
          status_nxt = ST_DONE;
          slot_nxt   = slot_field(free_idx_r);
          wr_en      = 1'b1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      FUNC_REMOVE: begin
        if (hit_r) begin
          status_nxt = ST_DONE;
          slot_nxt   = slot_field(hit_idx_r);
          clr_en     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      name_mem[free_idx_r]   <= name_r;
      sector_mem[free_idx_r] <= sector_r;
      dir_mem[free_idx_r]    <= dir_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (wr_en) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r     <= status_nxt;
      slot_r       <= slot_nxt;
      sector_out_r <= sector_out_nxt;
      is_dir_r     <= is_dir_nxt;
    end
  end

  assign status     = status_r;
  assign slot_index = slot_r;
  assign sector_out = sector_out_r;
  assign is_dir     = is_dir_r;

endmodule

// ----- sv/directory_name_table_core.sv -----
// Top level of the directory name table: controller plus datapath.
// Depends on dnt_pkg, dnt_if, dnt_ctrl and dnt_dpath.
//
//   Channel  Direction  Handshake     Payload
//   in_ch    sink       valid/ready   func, name_head, name_tail, sector_in, dir_flag_in
//   out_ch   source     valid/ready   status, slot_index, sector_out, is_dir
//
// Each request scans the slots in order: one slot is read from the slot memory
// per cycle, and the compare stage works on the registered read data. The scan
// stops at the first slot whose name matches, or after the last slot. Only one
// request is in work at a time, and the next one can transfer in the cycle after
// the result is loaded. Reset is synchronous and active low; it clears all valid bits,
// so the table is empty afterwards. A result waiting in the output register does not
// block the next request; only its commit waits for the output register to be free.
module directory_name_table_core import dnt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  dnt_in_if.sink       in_ch,
  dnt_out_if.source    out_ch
);

  dnt_cmd_t  cmd;
  dnt_stat_t stat;

  // The controller walks idle, scan and finish; the datapath does the work.
  dnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Request names are normalized on capture, so stored and requested names
  // compare with a plain equality during the scan.
  dnt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .func        (in_ch.func),
    .name_head   (in_ch.name_head),
    .name_tail   (in_ch.name_tail),
    .sector_in   (in_ch.sector_in),
    .dir_flag_in (in_ch.dir_flag_in),
    .status      (out_ch.status),
    .slot_index  (out_ch.slot_index),
    .sector_out  (out_ch.sector_out),
    .is_dir      (out_ch.is_dir)
  );

  // After an input transfer the block is busy with that request.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a request was still in work");

  // A commit never overwrites a result that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before transfer");

  // Every captured request is followed by a scan.
  a_scan_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.scan)
    else $error("request captured without a scan");

endmodule

// ----- test/directory_name_table_core_tb.sv -----
// Self-checking testbench for directory_name_table_core: lookups, adds and removes.
// It runs directed and random requests and checks each result against its own table.
// Depends on dnt_pkg, the channel interfaces in dnt_if and the core itself.
module directory_name_table_core_tb;
  import dnt_pkg::*;

  // Operation code that the block has no use for. It must answer not found and
  // leave the table alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int TOTAL_ITEMS    = 1400;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 2 * (ENTRIES + 3) + 10;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [HEAD_W-1:0]   name_head;
    logic [TAIL_W-1:0]   name_tail;
    logic [SECTOR_W-1:0] sector;
    logic                dir_flag;
  } dir_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
  } dir_resp_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Everything driven into the block starts at a known value at time zero.
  dir_req_t drv_req    = '0;
  logic     drv_valid  = 1'b0;
  logic     sink_ready = 1'b0;

  dnt_in_if  in_ch ();
  dnt_out_if out_ch ();

  assign in_ch.valid       = drv_valid;
  assign in_ch.func        = drv_req.func;
  assign in_ch.name_head   = drv_req.name_head;
  assign in_ch.name_tail   = drv_req.name_tail;
  assign in_ch.sector_in   = drv_req.sector;
  assign in_ch.dir_flag_in = drv_req.dir_flag;
  assign out_ch.ready      = sink_ready;

  directory_name_table_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be driven, and the results the table predicts for the
  // requests that have already been transferred, oldest first.
  dir_req_t  request_queue[$];
  dir_resp_t expected_replies[$];

  // Predicted contents of the table. Stored names are kept in canonical form,
  // with every byte after the terminator cleared.
  bit                  slot_used   [ENTRIES];
  logic [NAME_W-1:0]   slot_name   [ENTRIES];
  logic [SECTOR_W-1:0] slot_sector [ENTRIES];
  logic                slot_dir    [ENTRIES];

  int errors      = 0;
  int accepted    = 0;
  int returned    = 0;
  int idle_cycles = 0;
  int gap_left    = 0;
  int stall_left  = 0;
  bit in_quiet    = 1'b0;
  bit out_quiet   = 1'b0;

  logic [NAME_W-1:0] name_pool [POOL_SIZE];

  // Position of the first zero byte, or NAME_BYTES if the name fills all bytes.
  function automatic int name_length(input logic [NAME_W-1:0] name);
    for (int p = 0; p < NAME_BYTES; p++) begin
      if (name[8*p +: 8] == 8'd0) begin
        return p;
      end
    end
    return NAME_BYTES;
  endfunction

  // Keeps the first len bytes and clears the rest.
  function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] name, input int len);
    logic [NAME_W-1:0] res;
    res = name;
    for (int p = 0; p < NAME_BYTES; p++) begin
      if (p >= len) begin
        res[8*p +: 8] = 8'd0;
      end
    end
    return res;
  endfunction

  // Two names are equal when their bytes agree up to and including the first
  // position where both are zero; whatever follows is ignored.
  function automatic bit names_equal(input logic [NAME_W-1:0] a, input logic [NAME_W-1:0] b);
    for (int p = 0; p < NAME_BYTES; p++) begin
      if (a[8*p +: 8] != b[8*p +: 8]) begin
        return 1'b0;
      end
      if (a[8*p +: 8] == 8'd0) begin
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // Applies one request to the predicted table and returns the result it earns.
  function automatic dir_resp_t apply_request(input dir_req_t req);
    dir_resp_t         rsp;
    logic [NAME_W-1:0] req_name;
    int                hit;
    int                free_slot;
    rsp        = '0;
    rsp.status = ST_NOT_FOUND;
    req_name   = {req.name_tail, req.name_head};
    hit        = -1;
    free_slot  = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && names_equal(slot_name[i], req_name)) begin
        hit = i;
      end
      if (free_slot < 0 && !slot_used[i]) begin
        free_slot = i;
      end
    end
    case (req.func)
      FUNC_LOOKUP: begin
        if (hit >= 0) begin
          rsp.status = ST_DONE;
          rsp.slot   = SLOT_W'(hit);
          rsp.sector = slot_sector[hit];
          rsp.is_dir = slot_dir[hit];
        end
      end
      FUNC_ADD: begin
        // A duplicate wins over a full table.
        if (hit >= 0) begin
          rsp.status = ST_DUPLICATE;
        end else if (free_slot < 0) begin
          rsp.status = ST_FULL;
        end else begin
          slot_used[free_slot]   = 1'b1;
          slot_name[free_slot]   = cut_name(req_name, name_length(req_name));
          slot_sector[free_slot] = req.sector;
          slot_dir[free_slot]    = req.dir_flag;
          rsp.status = ST_DONE;
          rsp.slot   = SLOT_W'(free_slot);
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          rsp.status = ST_DONE;
          rsp.slot   = SLOT_W'(hit);
        end
      end
      default: begin
        // Unused code: not found, nothing changes.
      end
    endcase
    return rsp;
  endfunction

  function automatic logic [NAME_W-1:0] random_name(input int len);
    logic [NAME_W-1:0] res;
    res = '0;
    for (int p = 0; p < len; p++) begin
      res[8*p +: 8] = 8'($urandom_range(1, 255));
    end
    return res;
  endfunction

  // Fills the bytes after the terminator with junk, which a match must ignore.
  function automatic logic [NAME_W-1:0] add_junk(input logic [NAME_W-1:0] name);
    logic [NAME_W-1:0] res;
    int                len;
    res = name;
    len = name_length(name);
    for (int p = len + 1; p < NAME_BYTES; p++) begin
      res[8*p +: 8] = 8'($urandom_range(0, 255));
    end
    return res;
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] op, input logic [NAME_W-1:0] name,
                               input int sector, input bit dir);
    dir_req_t req;
    req.func      = op;
    req.name_head = name[HEAD_W-1:0];
    req.name_tail = name[NAME_W-1:HEAD_W];
    req.sector    = SECTOR_W'(sector);
    req.dir_flag  = dir;
    request_queue.push_back(req);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Driver. After each transfer it draws how many cycles to hold valid low
  // before the next request; in quiet stretches that is always zero, so valid
  // stays high across back-to-back transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      gap_left = $urandom_range(0, 7);
    end else begin
      if (drv_valid && in_ch.ready) begin
        expected_replies.push_back(apply_request(drv_req));
        accepted++;
        if (accepted % 150 == 0) begin
          in_quiet = ($urandom_range(0, 3) == 0);
        end
        gap_left = in_quiet ? 0 : $urandom_range(0, 7);
      end
      // A request that is still waiting for ready must be held as it is.
      if (!(drv_valid && !in_ch.ready)) begin
        if (gap_left == 0 && request_queue.size() > 0) begin
          drv_req   <= request_queue.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
          end
        end
      end
    end
  end

  // Monitor. Each result transfer is checked against the oldest prediction,
  // then ready drops for a randomly drawn number of cycles.
  always @(posedge clk) begin
    dir_resp_t got;
    dir_resp_t want;
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && sink_ready) begin
        got.status = out_ch.status;
        got.slot   = out_ch.slot_index;
        got.sector = out_ch.sector_out;
        got.is_dir = out_ch.is_dir;
        if (expected_replies.size() == 0) begin
          $display("%0t: result with no request pending, status %0d slot %0d sector %0d dir %0d",
                   $time, got.status, got.slot, got.sector, got.is_dir);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, got.status);
          check_field("slot_index", want.slot, got.slot);
          check_field("sector_out", want.sector, got.sector);
          check_field("is_dir", want.is_dir, got.is_dir);
        end
        returned++;
        if (returned % 150 == 0) begin
          out_quiet = ($urandom_range(0, 3) == 0);
        end
        stall_left = out_quiet ? 0 : $urandom_range(0, 7);
        sink_ready <= (stall_left == 0);
      end else if (!sink_ready) begin
        if (stall_left > 0) begin
          stall_left--;
        end else begin
          sink_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: a run that goes too long without any transfer has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((drv_valid && in_ch.ready) || (out_ch.valid && sink_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [NAME_W-1:0] all_ones;
    logic [NAME_W-1:0] short_name;
    logic [NAME_W-1:0] nm;
    logic [FUNC_W-1:0] op;
    int                mix;
    int                roll;
    int                add_w;
    int                rem_w;
    int                directed;

    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
    end

    // Name pool for the random part. It holds more names than the table has
    // slots, so the table fills up, and includes the empty name, a full-length
    // name and several of its prefixes to stress the terminator handling.
    name_pool[0] = '0;
    name_pool[1] = random_name(NAME_BYTES);
    for (int k = 2; k < 6; k++) begin
      name_pool[k] = cut_name(name_pool[1], k);
    end
    for (int k = 6; k < POOL_SIZE; k++) begin
      name_pool[k] = random_name($urandom_range(1, NAME_BYTES));
    end

    // Directed part: misses on an empty table, the unused code, extreme names,
    // sectors and flags, junk after the terminator, a full table, a duplicate
    // while full, and reuse of the lowest freed slot.
    all_ones   = '1;
    short_name = {{7{8'h00}}, 8'h62, 8'h61};
    queue_request(FUNC_REMOVE, short_name, 5, 1'b1);
    queue_request(FUNC_UNUSED, all_ones, 1023, 1'b1);
    queue_request(FUNC_ADD, '0, 0, 1'b0);
    queue_request(FUNC_ADD, all_ones, 1023, 1'b1);
    queue_request(FUNC_LOOKUP, all_ones, 0, 1'b0);
    queue_request(FUNC_LOOKUP, add_junk('0), 0, 1'b0);
    queue_request(FUNC_ADD, all_ones, 17, 1'b0);
    queue_request(FUNC_ADD, add_junk(short_name), 682, 1'b0);
    queue_request(FUNC_LOOKUP, add_junk(short_name), 0, 1'b1);
    queue_request(FUNC_LOOKUP, cut_name(all_ones, NAME_BYTES - 1), 0, 1'b0);
    for (int k = 0; k < ENTRIES - 3; k++) begin
      nm = random_name(1 + k % NAME_BYTES);
      nm[7:0] = 8'(8'h80 + k);
      queue_request(FUNC_ADD, nm, $urandom_range(0, 1023), 1'(k % 2));
    end
    queue_request(FUNC_ADD, {{8{8'h00}}, 8'h7f}, 341, 1'b1);
    queue_request(FUNC_ADD, all_ones, 1, 1'b1);
    queue_request(FUNC_REMOVE, short_name, 0, 1'b0);
    queue_request(FUNC_ADD, {{8{8'h00}}, 8'h7f}, 341, 1'b1);
    directed = request_queue.size();

    // Random part. The mix of operations changes every stretch so that the
    // table swings between nearly empty and full. Most names come from the
    // pool, some are near misses of pool names and some are pure noise.
    mix = 0;
    for (int n = directed; n < TOTAL_ITEMS; n++) begin
      if (n % 120 == 0) begin
        mix = $urandom_range(0, 2);
      end
      add_w = (mix == 0) ? 55 : (mix == 1) ? 15 : 33;
      rem_w = (mix == 0) ? 15 : (mix == 1) ? 55 : 33;
      roll  = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) begin
        op = FUNC_UNUSED;
      end else if (roll < add_w) begin
        op = FUNC_ADD;
      end else if (roll < add_w + rem_w) begin
        op = FUNC_REMOVE;
      end else begin
        op = FUNC_LOOKUP;
      end
      roll = $urandom_range(0, 99);
      nm   = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 75) begin
        nm = ($urandom_range(0, 1) == 1) ? add_junk(nm) : nm;
      end else if (roll < 87) begin
        if (name_length(nm) > 0) begin
          nm[8*$urandom_range(0, name_length(nm) - 1) +: 8] ^= 8'(1 << $urandom_range(0, 7));
        end
      end else begin
        nm = {8'($urandom), 32'($urandom), 32'($urandom)};
      end
      queue_request(op, nm, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() > 0 || drv_valid || expected_replies.size() > 0) begin
      @(posedge clk);
    end
    // Give a stray extra result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
